// ----- hdl/depth_pixel_backprojector_defines.svh -----
// Assertion macros for the checker file of the depth pixel backprojector.
// Expects signals named clock and reset in the scope of each use.
`ifndef DEPTH_PIXEL_BACKPROJECTOR_DEFINES_SVH
`define DEPTH_PIXEL_BACKPROJECTOR_DEFINES_SVH

// same-cycle implication
`define DPB_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dpb assertion failed");

// next-cycle implication
`define DPB_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dpb assertion failed");

`endif

// ----- hdl/dpb_pkg.sv -----
// Package for the depth pixel backprojector: widths, constants, register
// indexes and the structs passed between modules. No dependencies.
`default_nettype none

package dpb_pkg;

   localparam int MAX_DIM    = 4096;
   localparam int CNT_W      = $clog2(MAX_DIM);
   localparam int DIM_W      = 13;
   localparam int PH_W       = 4;
   localparam int STEP_W     = 5;
   localparam int STEP_MAX   = 16;
   localparam int DEPTH_W    = 24;
   localparam int COL_W      = 8;
   localparam int INV_W      = 32;
   localparam int CTR_W      = 28;
   localparam int POINT_W    = 32;
   localparam int POS_W      = CNT_W + 16;
   localparam int MAG_W      = (POS_W > CTR_W) ? POS_W : CTR_W;
   localparam int MUL_W      = 32;
   localparam int PROD_W     = 2 * MUL_W;
   localparam int R_W        = MAG_W + 17;
   localparam int RH_W       = R_W - 32;
   localparam int LO_W       = 32 + DEPTH_W;
   localparam int HI_W       = RH_W + DEPTH_W;
   localparam int RES_W      = HI_W + 1;
   localparam int CMP_W      = (CNT_W + 1 > DIM_W) ? CNT_W + 1 : DIM_W;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [DEPTH_W-1:0] DEPTH_LOW  = 24'd6553;
   localparam logic [DEPTH_W-1:0] DEPTH_HIGH = 24'd327680;

   localparam logic [INV_W-1:0]  RST_INV_FOCAL_X = 32'd6978852;
   localparam logic [INV_W-1:0]  RST_INV_FOCAL_Y = 32'd6866937;
   localparam logic [CTR_W-1:0]  RST_CENTER_X    = 28'd20895302;
   localparam logic [CTR_W-1:0]  RST_CENTER_Y    = 28'd15767568;
   localparam logic [DIM_W-1:0]  RST_WIDTH       = 13'd640;
   localparam logic [DIM_W-1:0]  RST_HEIGHT      = 13'd480;
   localparam logic [STEP_W-1:0] RST_STEP        = 5'd1;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_INV_FOCAL_X = 4'd0,
      REG_INV_FOCAL_Y = 4'd1,
      REG_CENTER_X    = 4'd2,
      REG_CENTER_Y    = 4'd3,
      REG_WIDTH       = 4'd4,
      REG_HEIGHT      = 4'd5,
      REG_STEP        = 4'd6,
      REG_GRAY_MODE   = 4'd7
   } reg_index_type;

   typedef enum logic [2:0] {
      OP_NONE = 3'd0,
      OP_MAG  = 3'd1,
      OP_MUL  = 3'd2,
      OP_RND  = 3'd3,
      OP_LO   = 3'd4,
      OP_HI   = 3'd5,
      OP_SAT  = 3'd6,
      OP_OUT  = 3'd7
   } op_type;

   // effective (clamped) configuration
   typedef struct packed {
      logic [INV_W-1:0]  inv_x;
      logic [INV_W-1:0]  inv_y;
      logic [CTR_W-1:0]  center_x;
      logic [CTR_W-1:0]  center_y;
      logic [DIM_W-1:0]  width;
      logic [DIM_W-1:0]  height;
      logic [STEP_W-1:0] step;
      logic              gray;
   } cfg_type;

   typedef struct packed {
      logic   accept;
      op_type op;
      logic   axis;    // 0: x, 1: y
   } cmd_type;

   typedef struct packed {
      logic keep;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

// ----- hdl/depth_pixel_backprojector.sv -----
// A kept pixel is accepted in idle, then each axis runs six steps on one shared 32x32
// multiplier: magnitude, multiply, round, low product, high product and saturate. The
// point then goes to the output register once that is free, and the next pixel is taken
// after it is loaded; a dropped pixel does not stall the input. Synchronous active-high
// reset clears the raster position and output valid and loads the register defaults.
// Top level: instances dpb_csr, dpb_ctrl and dpb_datapath; depends on dpb_pkg.
`default_nettype none

module depth_pixel_backprojector (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [dpb_pkg::DEPTH_W-1:0]    req_depth_q,
   input  wire logic                           req_depth_invalid,
   input  wire logic [dpb_pkg::COL_W-1:0]      req_red_in,
   input  wire logic [dpb_pkg::COL_W-1:0]      req_green_in,
   input  wire logic [dpb_pkg::COL_W-1:0]      req_blue_in,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic signed [dpb_pkg::POINT_W-1:0]  rsp_point_x,
   output logic signed [dpb_pkg::POINT_W-1:0]  rsp_point_y,
   output logic [dpb_pkg::DEPTH_W-1:0]         rsp_point_z,
   output logic [dpb_pkg::COL_W-1:0]           rsp_red_out,
   output logic [dpb_pkg::COL_W-1:0]           rsp_green_out,
   output logic [dpb_pkg::COL_W-1:0]           rsp_blue_out,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [dpb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [dpb_pkg::CSR_DATA_W-1:0] csr_data
);

   dpb_pkg::cfg_type    cfg;
   dpb_pkg::cmd_type    cmd;
   dpb_pkg::status_type status;

   dpb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   dpb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   dpb_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .cmd               (cmd),
      .status            (status),
      .req_depth_q       (req_depth_q),
      .req_depth_invalid (req_depth_invalid),
      .req_red_in        (req_red_in),
      .req_green_in      (req_green_in),
      .req_blue_in       (req_blue_in),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_point_x       (rsp_point_x),
      .rsp_point_y       (rsp_point_y),
      .rsp_point_z       (rsp_point_z),
      .rsp_red_out       (rsp_red_out),
      .rsp_green_out     (rsp_green_out),
      .rsp_blue_out      (rsp_blue_out)
   );

endmodule

`default_nettype wire

// ----- hdl/dpb_csr.sv -----
// Configuration registers of the depth pixel backprojector, with clamping
// of dimensions and step. Depends on dpb_pkg.
`default_nettype none

module dpb_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [dpb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [dpb_pkg::CSR_DATA_W-1:0] csr_data,
   output dpb_pkg::cfg_type                    cfg
);

   logic [dpb_pkg::INV_W-1:0]  inv_x_ff, inv_x_in;
   logic [dpb_pkg::INV_W-1:0]  inv_y_ff, inv_y_in;
   logic [dpb_pkg::CTR_W-1:0]  cx_ff, cx_in;
   logic [dpb_pkg::CTR_W-1:0]  cy_ff, cy_in;
   logic [dpb_pkg::DIM_W-1:0]  width_ff, width_in;
   logic [dpb_pkg::DIM_W-1:0]  height_ff, height_in;
   logic [dpb_pkg::STEP_W-1:0] step_ff, step_in;
   logic                       gray_ff, gray_in;

   assign csr_ready = 1'b1;

   always_comb begin
      inv_x_in  = inv_x_ff;
      inv_y_in  = inv_y_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      width_in  = width_ff;
      height_in = height_ff;
      step_in   = step_ff;
      gray_in   = gray_ff;
      if (csr_valid) begin
         unique case (csr_index)
            dpb_pkg::REG_INV_FOCAL_X: inv_x_in  = csr_data[dpb_pkg::INV_W-1:0];
            dpb_pkg::REG_INV_FOCAL_Y: inv_y_in  = csr_data[dpb_pkg::INV_W-1:0];
            dpb_pkg::REG_CENTER_X:    cx_in     = csr_data[dpb_pkg::CTR_W-1:0];
            dpb_pkg::REG_CENTER_Y:    cy_in     = csr_data[dpb_pkg::CTR_W-1:0];
            dpb_pkg::REG_WIDTH:       width_in  = csr_data[dpb_pkg::DIM_W-1:0];
            dpb_pkg::REG_HEIGHT:      height_in = csr_data[dpb_pkg::DIM_W-1:0];
            dpb_pkg::REG_STEP:        step_in   = csr_data[dpb_pkg::STEP_W-1:0];
            dpb_pkg::REG_GRAY_MODE:   gray_in   = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_x_ff  <= dpb_pkg::RST_INV_FOCAL_X;
         inv_y_ff  <= dpb_pkg::RST_INV_FOCAL_Y;
         cx_ff     <= dpb_pkg::RST_CENTER_X;
         cy_ff     <= dpb_pkg::RST_CENTER_Y;
         width_ff  <= dpb_pkg::RST_WIDTH;
         height_ff <= dpb_pkg::RST_HEIGHT;
         step_ff   <= dpb_pkg::RST_STEP;
         gray_ff   <= 1'b0;
      end else begin
         inv_x_ff  <= inv_x_in;
         inv_y_ff  <= inv_y_in;
         cx_ff     <= cx_in;
         cy_ff     <= cy_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         step_ff   <= step_in;
         gray_ff   <= gray_in;
      end
   end

   always_comb begin
      cfg.inv_x    = inv_x_ff;
      cfg.inv_y    = inv_y_ff;
      cfg.center_x = cx_ff;
      cfg.center_y = cy_ff;
      cfg.gray     = gray_ff;
      priority if (width_ff == '0)               cfg.width = dpb_pkg::DIM_W'(1);
      else if (width_ff > dpb_pkg::MAX_DIM)      cfg.width = dpb_pkg::DIM_W'(dpb_pkg::MAX_DIM);
      else                                       cfg.width = width_ff;
      priority if (height_ff == '0)              cfg.height = dpb_pkg::DIM_W'(1);
      else if (height_ff > dpb_pkg::MAX_DIM)     cfg.height = dpb_pkg::DIM_W'(dpb_pkg::MAX_DIM);
      else                                       cfg.height = height_ff;
      priority if (step_ff == '0)                cfg.step = dpb_pkg::STEP_W'(1);
      else if (step_ff > dpb_pkg::STEP_MAX)      cfg.step = dpb_pkg::STEP_W'(dpb_pkg::STEP_MAX);
      else                                       cfg.step = step_ff;
   end

endmodule

`default_nettype wire

// ----- hdl/dpb_ctrl.sv -----
// Sequencer of the depth pixel backprojector: steps the shared multiplier
// through both axes of a kept pixel. Depends on dpb_pkg.
`default_nettype none

module dpb_ctrl (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_stall,
   input  dpb_pkg::status_type status,
   output dpb_pkg::cmd_type    cmd
);

   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001,
      S_MAG  = 8'b0000_0010,
      S_MUL  = 8'b0000_0100,
      S_RND  = 8'b0000_1000,
      S_LO   = 8'b0001_0000,
      S_HI   = 8'b0010_0000,
      S_SAT  = 8'b0100_0000,
      S_OUT  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      axis_ff, axis_in;

   always_comb begin
      state_in   = state_ff;
      axis_in    = axis_ff;
      cmd.accept = 1'b0;
      cmd.axis   = axis_ff;
      cmd.op     = dpb_pkg::OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            cmd.accept = req_valid;
            if (req_valid && status.keep) begin
               state_in = S_MAG;
               axis_in  = 1'b0;
            end
         end
         S_MAG: begin
            cmd.op   = dpb_pkg::OP_MAG;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.op   = dpb_pkg::OP_MUL;
            state_in = S_RND;
         end
         S_RND: begin
            cmd.op   = dpb_pkg::OP_RND;
            state_in = S_LO;
         end
         S_LO: begin
            cmd.op   = dpb_pkg::OP_LO;
            state_in = S_HI;
         end
         S_HI: begin
            cmd.op   = dpb_pkg::OP_HI;
            state_in = S_SAT;
         end
         S_SAT: begin
            cmd.op = dpb_pkg::OP_SAT;
            if (axis_ff) begin
               state_in = S_OUT;
            end else begin
               state_in = S_MAG;
               axis_in  = 1'b1;
            end
         end
         S_OUT: begin
            cmd.op = dpb_pkg::OP_OUT;
            if (status.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         axis_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/dpb_datapath.sv -----
// Datapath of the depth pixel backprojector: raster counters, pixel filter,
// shared 32x32 multiplier, rounding, saturation and result register. Depends on dpb_pkg.
`default_nettype none

module dpb_datapath (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  dpb_pkg::cfg_type                  cfg,
   input  dpb_pkg::cmd_type                  cmd,
   output dpb_pkg::status_type               status,
   input  wire logic [dpb_pkg::DEPTH_W-1:0]  req_depth_q,
   input  wire logic                         req_depth_invalid,
   input  wire logic [dpb_pkg::COL_W-1:0]    req_red_in,
   input  wire logic [dpb_pkg::COL_W-1:0]    req_green_in,
   input  wire logic [dpb_pkg::COL_W-1:0]    req_blue_in,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic signed [dpb_pkg::POINT_W-1:0] rsp_point_x,
   output logic signed [dpb_pkg::POINT_W-1:0] rsp_point_y,
   output logic [dpb_pkg::DEPTH_W-1:0]       rsp_point_z,
   output logic [dpb_pkg::COL_W-1:0]         rsp_red_out,
   output logic [dpb_pkg::COL_W-1:0]         rsp_green_out,
   output logic [dpb_pkg::COL_W-1:0]         rsp_blue_out
);

   // raster position
   logic [dpb_pkg::CNT_W-1:0] col_ff, col_in, row_ff, row_in;
   logic [dpb_pkg::PH_W-1:0]  cph_ff, cph_in, rph_ff, rph_in;

   // captured pixel
   logic [dpb_pkg::CNT_W-1:0]   u_ff, u_in, v_ff, v_in;
   logic [dpb_pkg::DEPTH_W-1:0] z_ff, z_in;
   logic [dpb_pkg::COL_W-1:0]   r_col_ff, r_col_in, g_col_ff, g_col_in, b_col_ff, b_col_in;

   // arithmetic
   logic                        neg_ff, neg_in;
   logic [dpb_pkg::MAG_W-1:0]   mag_ff, mag_in;
   logic [dpb_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic [dpb_pkg::R_W-1:0]     rq_ff, rq_in;
   logic [dpb_pkg::LO_W-1:0]    lo_ff, lo_in;
   logic [dpb_pkg::POINT_W-1:0] px_ff, px_in, py_ff, py_in;

   // result register
   logic                        ov_ff, ov_in;
   logic [dpb_pkg::POINT_W-1:0] ox_ff, ox_in, oy_ff, oy_in;
   logic [dpb_pkg::DEPTH_W-1:0] oz_ff, oz_in;
   logic [dpb_pkg::COL_W-1:0]   or_ff, or_in, og_ff, og_in, ob_ff, ob_in;

   logic [dpb_pkg::MAG_W-1:0]   pos_a, ctr_c;
   logic [dpb_pkg::MUL_W-1:0]   mul_a, mul_b;
   logic [dpb_pkg::PROD_W-1:0]  mul_p;
   logic [dpb_pkg::LO_W:0]      lo_rnd;
   logic [dpb_pkg::RES_W-1:0]   res;
   logic [dpb_pkg::POINT_W-1:0] sat;
   logic                        col_wrap, row_wrap;

   assign status.keep = (cph_ff == '0) && (rph_ff == '0) && !req_depth_invalid
                        && (req_depth_q > dpb_pkg::DEPTH_LOW)
                        && (req_depth_q < dpb_pkg::DEPTH_HIGH);
   assign status.out_free = !ov_ff || !rsp_stall;

   assign col_wrap = (dpb_pkg::CMP_W'(col_ff) + dpb_pkg::CMP_W'(1))
                     >= dpb_pkg::CMP_W'(cfg.width);
   assign row_wrap = (dpb_pkg::CMP_W'(row_ff) + dpb_pkg::CMP_W'(1))
                     >= dpb_pkg::CMP_W'(cfg.height);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      cph_in = cph_ff;
      rph_in = rph_ff;
      if (cmd.accept) begin
         if (col_wrap) begin
            col_in = '0;
            cph_in = '0;
            if (row_wrap) begin
               row_in = '0;
               rph_in = '0;
            end else begin
               row_in = row_ff + dpb_pkg::CNT_W'(1);
               rph_in = ((dpb_pkg::STEP_W'(rph_ff) + dpb_pkg::STEP_W'(1)) >= cfg.step)
                        ? '0 : rph_ff + dpb_pkg::PH_W'(1);
            end
         end else begin
            col_in = col_ff + dpb_pkg::CNT_W'(1);
            cph_in = ((dpb_pkg::STEP_W'(cph_ff) + dpb_pkg::STEP_W'(1)) >= cfg.step)
                     ? '0 : cph_ff + dpb_pkg::PH_W'(1);
         end
      end
   end

   always_comb begin
      u_in     = u_ff;
      v_in     = v_ff;
      z_in     = z_ff;
      r_col_in = r_col_ff;
      g_col_in = g_col_ff;
      b_col_in = b_col_ff;
      if (cmd.accept) begin
         u_in     = col_ff;
         v_in     = row_ff;
         z_in     = req_depth_q;
         r_col_in = req_red_in;
         g_col_in = cfg.gray ? req_red_in : req_green_in;
         b_col_in = cfg.gray ? req_red_in : req_blue_in;
      end
   end

   // operand selection for the shared multiplier
   always_comb begin
      pos_a = dpb_pkg::MAG_W'({(cmd.axis ? v_ff : u_ff), 16'h0000});
      ctr_c = dpb_pkg::MAG_W'(cmd.axis ? cfg.center_y : cfg.center_x);
      unique case (cmd.op)
         dpb_pkg::OP_LO: begin
            mul_a = rq_ff[31:0];
            mul_b = dpb_pkg::MUL_W'(z_ff);
         end
         dpb_pkg::OP_HI: begin
            mul_a = dpb_pkg::MUL_W'(rq_ff[dpb_pkg::R_W-1:32]);
            mul_b = dpb_pkg::MUL_W'(z_ff);
         end
         default: begin
            mul_a = dpb_pkg::MUL_W'(mag_ff);
            mul_b = cmd.axis ? cfg.inv_y : cfg.inv_x;
         end
      endcase
      mul_p = dpb_pkg::PROD_W'(mul_a) * dpb_pkg::PROD_W'(mul_b);
   end

   // rounding of the low product and saturation
   always_comb begin
      lo_rnd = (dpb_pkg::LO_W+1)'(lo_ff) + (dpb_pkg::LO_W+1)'(33'h0_8000_0000);
      res    = dpb_pkg::RES_W'(prod_ff[dpb_pkg::HI_W-1:0])
               + dpb_pkg::RES_W'(lo_rnd[dpb_pkg::LO_W:32]);
      if (neg_ff) begin
         if (res >= dpb_pkg::RES_W'(33'h0_8000_0000)) sat = 32'h8000_0000;
         else                                         sat = ~res[31:0] + 32'd1;
      end else begin
         if (res > dpb_pkg::RES_W'(32'h7FFF_FFFF)) sat = 32'h7FFF_FFFF;
         else                                      sat = res[31:0];
      end
   end

   always_comb begin
      neg_in  = neg_ff;
      mag_in  = mag_ff;
      prod_in = prod_ff;
      rq_in   = rq_ff;
      lo_in   = lo_ff;
      px_in   = px_ff;
      py_in   = py_ff;
      unique case (cmd.op)
         dpb_pkg::OP_MAG: begin
            neg_in = pos_a < ctr_c;
            mag_in = (pos_a < ctr_c) ? ctr_c - pos_a : pos_a - ctr_c;
         end
         dpb_pkg::OP_MUL: prod_in = mul_p;
         dpb_pkg::OP_RND: begin
            rq_in = dpb_pkg::R_W'(prod_ff[dpb_pkg::PROD_W-1:16])
                    + dpb_pkg::R_W'(prod_ff[15]);
         end
         dpb_pkg::OP_LO: prod_in = mul_p;
         dpb_pkg::OP_HI: begin
            lo_in   = prod_ff[dpb_pkg::LO_W-1:0];
            prod_in = mul_p;
         end
         dpb_pkg::OP_SAT: begin
            if (cmd.axis) py_in = sat;
            else          px_in = sat;
         end
         default: ;
      endcase
   end

   always_comb begin
      ov_in = ov_ff;
      ox_in = ox_ff;
      oy_in = oy_ff;
      oz_in = oz_ff;
      or_in = or_ff;
      og_in = og_ff;
      ob_in = ob_ff;
      if (ov_ff && !rsp_stall) begin
         ov_in = 1'b0;
      end
      if ((cmd.op == dpb_pkg::OP_OUT) && status.out_free) begin
         ov_in = 1'b1;
         ox_in = px_ff;
         oy_in = py_ff;
         oz_in = z_ff;
         or_in = r_col_ff;
         og_in = g_col_ff;
         ob_in = b_col_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         cph_ff <= '0;
         rph_ff <= '0;
         ov_ff  <= 1'b0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         cph_ff <= cph_in;
         rph_ff <= rph_in;
         ov_ff  <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      u_ff     <= u_in;
      v_ff     <= v_in;
      z_ff     <= z_in;
      r_col_ff <= r_col_in;
      g_col_ff <= g_col_in;
      b_col_ff <= b_col_in;
      neg_ff   <= neg_in;
      mag_ff   <= mag_in;
      prod_ff  <= prod_in;
      rq_ff    <= rq_in;
      lo_ff    <= lo_in;
      px_ff    <= px_in;
      py_ff    <= py_in;
      ox_ff    <= ox_in;
      oy_ff    <= oy_in;
      oz_ff    <= oz_in;
      or_ff    <= or_in;
      og_ff    <= og_in;
      ob_ff    <= ob_in;
   end

   assign rsp_valid     = ov_ff;
   assign rsp_point_x   = ox_ff;
   assign rsp_point_y   = oy_ff;
   assign rsp_point_z   = oz_ff;
   assign rsp_red_out   = or_ff;
   assign rsp_green_out = og_ff;
   assign rsp_blue_out  = ob_ff;

endmodule

`default_nettype wire

// ----- hdl/dpb_checker.sv -----
// Port-level checks of the depth pixel backprojector and its bind.
// Depends on dpb_pkg and depth_pixel_backprojector_defines.svh.
`default_nettype none
`include "depth_pixel_backprojector_defines.svh"

module dpb_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_stall,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_stall,
   input wire logic [dpb_pkg::POINT_W-1:0]    rsp_point_x,
   input wire logic [dpb_pkg::POINT_W-1:0]    rsp_point_y,
   input wire logic [dpb_pkg::DEPTH_W-1:0]    rsp_point_z,
   input wire logic [dpb_pkg::COL_W-1:0]      rsp_red_out,
   input wire logic [dpb_pkg::COL_W-1:0]      rsp_green_out,
   input wire logic [dpb_pkg::COL_W-1:0]      rsp_blue_out
);

   logic [2*dpb_pkg::POINT_W+dpb_pkg::DEPTH_W+3*dpb_pkg::COL_W-1:0] rsp_payload;
   logic                                                           depth_in_range;

   assign rsp_payload = {rsp_point_x, rsp_point_y, rsp_point_z,
                         rsp_red_out, rsp_green_out, rsp_blue_out};
   assign depth_in_range = (rsp_point_z > dpb_pkg::DEPTH_LOW)
                           && (rsp_point_z < dpb_pkg::DEPTH_HIGH);

   `DPB_ASSERT_NEXT(a_rsp_held, rsp_valid && rsp_stall, rsp_valid)

   `DPB_ASSERT_NEXT(a_rsp_stable, rsp_valid && rsp_stall, $stable(rsp_payload))

   // every point comes from a depth strictly inside the working range
   `DPB_ASSERT_NOW(a_depth_range, rsp_valid, depth_in_range)

   // a new point is only loaded while the input side is held off
   `DPB_ASSERT_NOW(a_load_busy, $rose(rsp_valid), $past(req_stall))

endmodule

bind depth_pixel_backprojector dpb_checker u_dpb_checker (.*);

`default_nettype wire
